>>> rtl/gpio_exp_pkg.sv
`default_nettype none

package gpio_exp_pkg;

  // field widths
  localparam int unsigned OpW      = 3;
  localparam int unsigned BankFW   = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LevelW   = 40;
  localparam int unsigned PinFW    = 6;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned MaxPins  = 64;

  // stream word widths
  localparam int unsigned InTdataW  = 64;
  localparam int unsigned OutTdataW = 64;
  localparam int unsigned OutTuserW = 1;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OpSet    = 3'd0,
    OpClear  = 3'd1,
    OpToggle = 3'd2,
    OpGet    = 3'd3,
    OpSample = 3'd4,
    OpAttach = 3'd5
  } op_e;

  // event mode codes
  localparam logic [ModeW-1:0] ModeOff  = 2'd0;
  localparam logic [ModeW-1:0] ModeRise = 2'd1;
  localparam logic [ModeW-1:0] ModeFall = 2'd2;
  localparam logic [ModeW-1:0] ModeAny  = 2'd3;

  // input word, op in the lowest bits and pad in the highest
  typedef struct packed {
    logic [1:0]        pad;
    logic [ModeW-1:0]  event_mode;
    logic [PinFW-1:0]  pin_index;
    logic [LevelW-1:0] pin_levels;
    logic [ByteW-1:0]  mask;
    logic [BankFW-1:0] bank;
    logic [OpW-1:0]    op;
  } in_word_t;

  // result word
  typedef struct packed {
    logic              write_valid;
    logic [LevelW-1:0] event_pins;
    logic [ByteW-1:0]  read_byte;
    logic [ByteW-1:0]  write_byte;
    logic [BankFW-1:0] write_bank;
  } res_t;

  // does one pin's change match its mode
  function automatic logic pin_match(logic [ModeW-1:0] mode, logic was, logic now);
    logic hit;
    case (mode)
      ModeRise: hit = now & ~was;
      ModeFall: hit = ~now & was;
      ModeAny:  hit = now ^ was;
      default:  hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

>>> rtl/gpio_expander_pin_events.sv
`default_nettype none

// channel  | group        | fields (lowest bit up)
// ---------+--------------+---------------------------------------------------
// input    | s_axis_*     | tdata: op, bank, mask, pin_levels, pin_index,
//          |              |        event_mode
// output   | m_axis_*     | tdata: write_bank, write_byte, read_byte,
//          |              |        event_pins; tuser: write_valid
//
// one word is taken per cycle while the skid register is empty; its result
// is registered, and waits in the skid register while the output stalls.
// latch and mode updates land in the accepting cycle; the next word sees them.
// a two-entry output stage (result register and skid register) lets input
// run on while the output stalls; s_axis_tready drops only when both hold.
// reset clears the pin latch, all event modes and both valid flags.

module gpio_expander_pin_events #(
  parameter int unsigned BANKS = 5
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output      logic                                 s_axis_tready,
  // op, bank, mask, pin_levels, pin_index, event_mode
  input  wire logic [gpio_exp_pkg::InTdataW-1:0]    s_axis_tdata,
  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // write_bank, write_byte, read_byte, event_pins
  output      logic [gpio_exp_pkg::OutTdataW-1:0]   m_axis_tdata,
  // write_valid
  output      logic [gpio_exp_pkg::OutTuserW-1:0]   m_axis_tuser
);
  import gpio_exp_pkg::*;

  localparam int unsigned Pins  = BANKS * 8;
  localparam int unsigned BankW = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int unsigned PinW  = $clog2(Pins);

  // state
  logic [ByteW-1:0] latch_q [BANKS];
  logic [ByteW-1:0] latch_d [BANKS];
  logic [ModeW-1:0] mode_q  [Pins];
  logic [ModeW-1:0] mode_d  [Pins];

  // output stage
  res_t out_q, skid_q, res;
  logic out_valid_q, skid_valid_q;

  in_word_t         in_w;
  logic             in_fire, out_fire;
  logic             bank_ok, pin_ok;
  logic [BankW-1:0] bidx;
  logic [PinW-1:0]  pidx;
  logic [ByteW-1:0] old_byte, new_byte;
  logic [MaxPins-1:0] lvl_ext, ev_ext;

  assign in_w     = in_word_t'(s_axis_tdata);
  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_fire = m_axis_tvalid & m_axis_tready;
  assign bank_ok  = {1'b0, in_w.bank} < 4'(BANKS);
  assign pin_ok   = {1'b0, in_w.pin_index} < 7'(Pins);
  assign bidx     = in_w.bank[BankW-1:0];
  assign pidx     = in_w.pin_index[PinW-1:0];
  assign lvl_ext  = MaxPins'(in_w.pin_levels);
  assign old_byte = latch_q[bidx];

  // operation decode and next state
  always_comb begin
    res      = '0;
    latch_d  = latch_q;
    mode_d   = mode_q;
    new_byte = old_byte;
    ev_ext   = '0;
    case (op_e'(in_w.op))
      OpSet, OpClear, OpToggle: begin
        case (op_e'(in_w.op))
          OpSet:   new_byte = old_byte | in_w.mask;
          OpClear: new_byte = old_byte & ~in_w.mask;
          default: new_byte = old_byte ^ in_w.mask;
        endcase
        if (bank_ok) begin
          latch_d[bidx]   = new_byte;
          res.write_valid = 1'b1;
          res.write_bank  = in_w.bank;
          res.write_byte  = new_byte;
        end
      end
      OpGet: begin
        if (bank_ok) begin
          res.read_byte = old_byte & in_w.mask;
        end
      end
      OpSample: begin
        for (int unsigned p = 0; p < Pins; p++) begin
          ev_ext[p] = pin_match(mode_q[p], latch_q[p/8][p%8], lvl_ext[p]);
        end
        for (int unsigned b = 0; b < BANKS; b++) begin
          latch_d[b] = lvl_ext[8*b +: 8];
        end
        res.event_pins = ev_ext[LevelW-1:0];
      end
      OpAttach: begin
        if (pin_ok) begin
          mode_d[pidx] = in_w.event_mode;
        end
      end
      default: ;
    endcase
  end

  // latch and mode registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned b = 0; b < BANKS; b++) latch_q[b] <= '0;
      for (int unsigned p = 0; p < Pins; p++)  mode_q[p]  <= ModeOff;
    end else if (in_fire) begin
      latch_q <= latch_d;
      mode_q  <= mode_d;
    end
  end

  // output stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  // output stage payload
  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign s_axis_tready = ~skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.write_valid;
  assign m_axis_tdata  = OutTdataW'({out_q.event_pins, out_q.read_byte,
                                     out_q.write_byte, out_q.write_bank});

endmodule

`default_nettype wire
